// ===== src/nrom_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the nearest resize offset map.
// No dependencies; every other file takes names from here by scope.
package nrom_pkg;

  // Geometry limits
  localparam int MAX_DIM   = 4096;
  localparam int IDX_W     = $clog2(MAX_DIM);  // destination index, start, position
  localparam int DIM_W     = IDX_W + 1;        // ends and destination extents
  localparam int STEP_W    = 16;              // widest axis step
  localparam int PIX_W     = 4;               // column step
  localparam int OFF_W     = 27;              // source byte offset
  localparam int PROD_W    = IDX_W + DIM_W - 1; // index * extent stays below this
  localparam int SCALE_W   = IDX_W + STEP_W;  // position * step
  localparam int DIV_FIRST = 2;               // select and multiply come first
  localparam int DIV_STAGES = IDX_W;          // one quotient bit per stage
  localparam int NUM_STAGES = DIV_FIRST + DIV_STAGES + 2;

  localparam logic [DIM_W-1:0] DIM_SAT   = DIM_W'(MAX_DIM);
  localparam logic [OFF_W-1:0] OFF_MAX   = {OFF_W{1'b1}};

  // APB port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register indexes
  typedef enum logic [2:0] {
    REG_CROP_X_START = 3'd0,
    REG_CROP_X_END   = 3'd1,
    REG_CROP_Y_START = 3'd2,
    REG_CROP_Y_END   = 3'd3,
    REG_DEST_COLS    = 3'd4,
    REG_DEST_ROWS    = 3'd5,
    REG_PIXEL_BYTES  = 3'd6,
    REG_LINE_BYTES   = 3'd7
  } reg_idx_t;

  // Axis codes
  localparam logic AXIS_COL = 1'b0;
  localparam logic AXIS_ROW = 1'b1;

  // Register file contents
  typedef struct packed {
    logic [IDX_W-1:0]  crop_x_start;
    logic [DIM_W-1:0]  crop_x_end;
    logic [IDX_W-1:0]  crop_y_start;
    logic [DIM_W-1:0]  crop_y_end;
    logic [DIM_W-1:0]  dest_cols;
    logic [DIM_W-1:0]  dest_rows;
    logic [PIX_W-1:0]  pixel_bytes;
    logic [STEP_W-1:0] line_bytes;
  } cfg_t;

  // Per-item context carried down the pipeline
  typedef struct packed {
    logic              axis;
    logic              err;
    logic [IDX_W-1:0]  start;
    logic [IDX_W-1:0]  lastpos;
    logic [STEP_W-1:0] step;
    logic [DIM_W-1:0]  dext;
  } ctx_t;

  // Divider word: partial remainder and dividend bits turning into quotient bits
  typedef struct packed {
    ctx_t             ctx;
    logic [IDX_W-1:0] rem;
    logic [IDX_W-1:0] acc;
  } div_t;

endpackage

// ===== src/nrom_cfg_regs.sv =====
`timescale 1ns / 1ps
// APB register file holding the crop, destination extent and step registers.
// Depends on nrom_pkg.
module nrom_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nrom_pkg::ADDR_W-1:0]   paddr,
  input  logic [nrom_pkg::DATA_W-1:0]   pwdata,
  output logic [nrom_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output nrom_pkg::cfg_t                cfg
);

  nrom_pkg::reg_idx_t ridx;
  logic               wr;

  assign ridx   = nrom_pkg::reg_idx_t'(paddr[nrom_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write one register per access beat
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.crop_x_start <= '0;
      cfg.crop_x_end   <= nrom_pkg::DIM_W'(1);
      cfg.crop_y_start <= '0;
      cfg.crop_y_end   <= nrom_pkg::DIM_W'(1);
      cfg.dest_cols    <= nrom_pkg::DIM_W'(1);
      cfg.dest_rows    <= nrom_pkg::DIM_W'(1);
      cfg.pixel_bytes  <= nrom_pkg::PIX_W'(1);
      cfg.line_bytes   <= nrom_pkg::STEP_W'(1);
    end else if (wr) begin
      unique case (ridx)
        nrom_pkg::REG_CROP_X_START: cfg.crop_x_start <= pwdata[nrom_pkg::IDX_W-1:0];
        nrom_pkg::REG_CROP_X_END:   cfg.crop_x_end   <= pwdata[nrom_pkg::DIM_W-1:0];
        nrom_pkg::REG_CROP_Y_START: cfg.crop_y_start <= pwdata[nrom_pkg::IDX_W-1:0];
        nrom_pkg::REG_CROP_Y_END:   cfg.crop_y_end   <= pwdata[nrom_pkg::DIM_W-1:0];
        nrom_pkg::REG_DEST_COLS:    cfg.dest_cols    <= pwdata[nrom_pkg::DIM_W-1:0];
        nrom_pkg::REG_DEST_ROWS:    cfg.dest_rows    <= pwdata[nrom_pkg::DIM_W-1:0];
        nrom_pkg::REG_PIXEL_BYTES:  cfg.pixel_bytes  <= pwdata[nrom_pkg::PIX_W-1:0];
        nrom_pkg::REG_LINE_BYTES:   cfg.line_bytes   <= pwdata[nrom_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back, zero extended
  always_comb begin
    unique case (ridx)
      nrom_pkg::REG_CROP_X_START: prdata = nrom_pkg::DATA_W'(cfg.crop_x_start);
      nrom_pkg::REG_CROP_X_END:   prdata = nrom_pkg::DATA_W'(cfg.crop_x_end);
      nrom_pkg::REG_CROP_Y_START: prdata = nrom_pkg::DATA_W'(cfg.crop_y_start);
      nrom_pkg::REG_CROP_Y_END:   prdata = nrom_pkg::DATA_W'(cfg.crop_y_end);
      nrom_pkg::REG_DEST_COLS:    prdata = nrom_pkg::DATA_W'(cfg.dest_cols);
      nrom_pkg::REG_DEST_ROWS:    prdata = nrom_pkg::DATA_W'(cfg.dest_rows);
      nrom_pkg::REG_PIXEL_BYTES:  prdata = nrom_pkg::DATA_W'(cfg.pixel_bytes);
      nrom_pkg::REG_LINE_BYTES:   prdata = nrom_pkg::DATA_W'(cfg.line_bytes);
      default:                    prdata = '0;
    endcase
  end

endmodule

// ===== src/nrom_front.sv =====
`timescale 1ns / 1ps
// Front of the map pipeline: axis select with saturation, then index * extent.
// Depends on nrom_pkg.
module nrom_front (
  input  logic                         clk,
  input  logic                         rst,
  input  nrom_pkg::cfg_t               cfg,
  input  logic                         en_sel,
  input  logic                         en_mul,
  input  logic                         in_valid,
  input  logic                         req_type,
  input  logic [nrom_pkg::IDX_W-1:0]   dst_index,
  output logic                         sel_valid,
  output logic                         mul_valid,
  output nrom_pkg::div_t               mul_out
);

  logic [nrom_pkg::IDX_W-1:0]  start_raw;
  logic [nrom_pkg::DIM_W-1:0]  end_raw;
  logic [nrom_pkg::DIM_W-1:0]  dext_raw;
  logic [nrom_pkg::DIM_W-1:0]  end_sat;
  logic [nrom_pkg::DIM_W-1:0]  dext_sat;
  logic [nrom_pkg::DIM_W-1:0]  ext_next;
  nrom_pkg::ctx_t              ctx_next;
  logic [nrom_pkg::PROD_W-1:0] prod;

  // Select stage registers
  nrom_pkg::ctx_t              sel_ctx;
  logic [nrom_pkg::IDX_W-1:0]  sel_idx;
  logic [nrom_pkg::DIM_W-1:0]  sel_ext;

  // Pick the axis and saturate out-of-range registers
  always_comb begin
    if (req_type == nrom_pkg::AXIS_ROW) begin
      start_raw     = cfg.crop_y_start;
      end_raw       = cfg.crop_y_end;
      dext_raw      = cfg.dest_rows;
      ctx_next.step = cfg.line_bytes;
    end else begin
      start_raw     = cfg.crop_x_start;
      end_raw       = cfg.crop_x_end;
      dext_raw      = cfg.dest_cols;
      ctx_next.step = nrom_pkg::STEP_W'(cfg.pixel_bytes);
    end
    end_sat  = (end_raw > nrom_pkg::DIM_SAT) ? nrom_pkg::DIM_SAT : end_raw;
    dext_sat = (dext_raw > nrom_pkg::DIM_SAT) ? nrom_pkg::DIM_SAT : dext_raw;

    ctx_next.axis    = req_type;
    ctx_next.start   = start_raw;
    ctx_next.dext    = dext_sat;
    ctx_next.err     = ({1'b0, dst_index} >= dext_sat);
    // Empty or inverted crop counts as zero extent
    ext_next         = (end_sat > {1'b0, start_raw}) ? (end_sat - {1'b0, start_raw}) : '0;
    ctx_next.lastpos = (end_sat != '0) ? nrom_pkg::IDX_W'(end_sat - nrom_pkg::DIM_W'(1)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_valid <= 1'b0;
    end else if (en_sel) begin
      sel_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_sel) begin
      sel_ctx <= ctx_next;
      sel_idx <= dst_index;
      sel_ext <= ext_next;
    end
  end

  // Product stays below MAX_DIM * dext, so its top half starts the remainder
  assign prod = nrom_pkg::PROD_W'(sel_idx * sel_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (en_mul) begin
      mul_valid <= sel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_mul) begin
      mul_out.ctx <= sel_ctx;
      mul_out.rem <= prod[nrom_pkg::PROD_W-1:nrom_pkg::IDX_W];
      mul_out.acc <= prod[nrom_pkg::IDX_W-1:0];
    end
  end

endmodule

// ===== src/nrom_div_stage.sv =====
`timescale 1ns / 1ps
// One restoring division stage: retires one quotient bit per cycle while its enable is high.
// Depends on nrom_pkg.
module nrom_div_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  nrom_pkg::div_t in_data,
  output logic           out_valid,
  output nrom_pkg::div_t out_data
);

  logic [nrom_pkg::DIM_W-1:0] trial;
  logic                       ge;
  nrom_pkg::div_t             data_next;

  // Shift in the next dividend bit, subtract the divisor if it fits
  always_comb begin
    trial              = {in_data.rem, in_data.acc[nrom_pkg::IDX_W-1]};
    ge                 = (trial >= in_data.ctx.dext);
    data_next.ctx      = in_data.ctx;
    data_next.rem      = ge ? nrom_pkg::IDX_W'(trial - in_data.ctx.dext)
                            : trial[nrom_pkg::IDX_W-1:0];
    data_next.acc      = {in_data.acc[nrom_pkg::IDX_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== src/nrom_back.sv =====
`timescale 1ns / 1ps
// Back of the map pipeline: add start and clamp, then scale by the step.
// Depends on nrom_pkg.
module nrom_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en_clamp,
  input  logic                         en_scale,
  input  logic                         in_valid,
  input  nrom_pkg::div_t               in_data,
  output logic                         clamp_valid,
  output logic                         res_valid,
  output logic                         axis,
  output logic [nrom_pkg::OFF_W-1:0]   src_offset,
  output logic                         index_error
);

  logic [nrom_pkg::DIM_W-1:0]   sum;
  logic [nrom_pkg::IDX_W-1:0]   pos_next;
  logic [nrom_pkg::SCALE_W-1:0] scaled;
  logic [nrom_pkg::OFF_W-1:0]   off_next;

  // Clamp stage registers
  logic                         cl_axis;
  logic                         cl_err;
  logic [nrom_pkg::STEP_W-1:0]  cl_step;
  logic [nrom_pkg::IDX_W-1:0]   cl_pos;

  // Position is quotient plus start, held at the last source position
  always_comb begin
    sum      = {1'b0, in_data.acc} + {1'b0, in_data.ctx.start};
    pos_next = (sum > {1'b0, in_data.ctx.lastpos}) ? in_data.ctx.lastpos
                                                   : sum[nrom_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clamp_valid <= 1'b0;
    end else if (en_clamp) begin
      clamp_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_clamp) begin
      cl_axis <= in_data.ctx.axis;
      cl_err  <= in_data.ctx.err;
      cl_step <= in_data.ctx.step;
      cl_pos  <= pos_next;
    end
  end

  // Scale to bytes and saturate; a flagged index gives offset zero
  always_comb begin
    scaled = cl_pos * cl_step;
    if (cl_err) begin
      off_next = '0;
    end else if (scaled > nrom_pkg::SCALE_W'(nrom_pkg::OFF_MAX)) begin
      off_next = nrom_pkg::OFF_MAX;
    end else begin
      off_next = scaled[nrom_pkg::OFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en_scale) begin
      res_valid <= clamp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_scale) begin
      axis        <= cl_axis;
      src_offset  <= off_next;
      index_error <= cl_err;
    end
  end

endmodule

// ===== src/nearest_resize_offset_map_core.sv =====
`timescale 1ns / 1ps
// Top level of the nearest resize offset map: register file and 16-stage pipeline.
// Depends on nrom_pkg, nrom_cfg_regs, nrom_front, nrom_div_stage, nrom_back.
//
//   Port group   Direction  Handshake              Payload
//   request      in         req_valid / req_stall   req_type, dst_index
//   result       out        res_valid / res_stall   axis, src_offset, index_error
//   config       in/out     APB (psel, penable)     paddr, pwdata, prdata
//
// One request per cycle while req_stall is low; a result is presented once its request
// beat has passed 16 register stages (select, multiply, twelve one-bit divider stages,
// clamp, scale), and can be taken at the next edge.
// Reset clears all valid bits and loads the register reset values.
// Stalls propagate per stage: a stage holds only when it is full and the stage
// after it holds, so bubbles are squeezed out while the result beat waits.
module nearest_resize_offset_map_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nrom_pkg::ADDR_W-1:0]   paddr,
  input  logic [nrom_pkg::DATA_W-1:0]   pwdata,
  output logic [nrom_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          req_type,
  input  logic [nrom_pkg::IDX_W-1:0]    dst_index,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic                          axis,
  output logic [nrom_pkg::OFF_W-1:0]    src_offset,
  output logic                          index_error
);

  nrom_pkg::cfg_t                      cfg;
  logic [nrom_pkg::NUM_STAGES-1:0]     vld;
  logic [nrom_pkg::NUM_STAGES-1:0]     en;
  nrom_pkg::div_t                      div_data [nrom_pkg::DIV_STAGES+1];

  nrom_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance a stage when it is empty or the next stage advances
  assign en[nrom_pkg::NUM_STAGES-1] = !vld[nrom_pkg::NUM_STAGES-1] || !res_stall;
  for (genvar k = 0; k < nrom_pkg::NUM_STAGES-1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  assign req_stall = !en[0];

  nrom_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .en_sel    (en[0]),
    .en_mul    (en[1]),
    .in_valid  (req_valid),
    .req_type  (req_type),
    .dst_index (dst_index),
    .sel_valid (vld[0]),
    .mul_valid (vld[1]),
    .mul_out   (div_data[0])
  );

  for (genvar k = 0; k < nrom_pkg::DIV_STAGES; k++) begin : g_div
    nrom_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (en[nrom_pkg::DIV_FIRST+k]),
      .in_valid  (vld[nrom_pkg::DIV_FIRST+k-1]),
      .in_data   (div_data[k]),
      .out_valid (vld[nrom_pkg::DIV_FIRST+k]),
      .out_data  (div_data[k+1])
    );
  end

  nrom_back u_back (
    .clk         (clk),
    .rst         (rst),
    .en_clamp    (en[nrom_pkg::NUM_STAGES-2]),
    .en_scale    (en[nrom_pkg::NUM_STAGES-1]),
    .in_valid    (vld[nrom_pkg::NUM_STAGES-3]),
    .in_data     (div_data[nrom_pkg::DIV_STAGES]),
    .clamp_valid (vld[nrom_pkg::NUM_STAGES-2]),
    .res_valid   (vld[nrom_pkg::NUM_STAGES-1]),
    .axis        (axis),
    .src_offset  (src_offset),
    .index_error (index_error)
  );

  assign res_valid = vld[nrom_pkg::NUM_STAGES-1];

`ifndef SYNTHESIS
  // A flagged index never carries an offset
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && index_error) |-> (src_offset == '0))
    else $error("flagged index with non-zero offset");

  // Requests are held back only when the whole pipeline is full and blocked
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (res_valid && res_stall && (&vld)))
    else $error("request stalled with room in the pipeline");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!res_valid && !req_stall))
    else $error("pipeline not empty after reset");
`endif

endmodule
